@@ rtl/core/phong_brdf_evaluation_assert.svh @@
// Assertion macros for the Phong shading core.
// Users must have aclk and aresetn (active-low synchronous reset) in scope.
`ifndef PHONG_BRDF_EVALUATION_ASSERT_SVH
`define PHONG_BRDF_EVALUATION_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PBE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define PBE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/pbe_pkg.sv @@
// Shared types, constants and table generators for the Phong shading core.
// No dependencies.
package pbe_pkg;

    localparam int unsigned LOG_TABLE_BITS_DEF = 10;
    localparam int unsigned QUEUE_DEPTH_DEF    = 4;
    localparam int unsigned NUM_CH             = 3;
    localparam int unsigned CFG_IDX_W          = 3;
    localparam longint unsigned LN2_Q30        = 64'd744261118;
    localparam logic [16:0] ONE_Q16            = 17'd65536;
    localparam logic [15:0] COLOR_RESET        = 16'd4096;
    localparam logic [15:0] SHINE_RESET        = 16'd256;
    localparam logic signed [24:0] SAT_MAX     = 25'sd524287;
    localparam logic signed [24:0] SAT_MIN     = -25'sd524288;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIFFUSE_RED    = 3'd0,
        CFG_DIFFUSE_GREEN  = 3'd1,
        CFG_DIFFUSE_BLUE   = 3'd2,
        CFG_SPECULAR_RED   = 3'd3,
        CFG_SPECULAR_GREEN = 3'd4,
        CFG_SPECULAR_BLUE  = 3'd5,
        CFG_SHININESS      = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [NUM_CH-1:0][15:0] diffuse;   // Q4.12
        logic [NUM_CH-1:0][15:0] specular;  // Q4.12
        logic [15:0]             shininess; // Q8.8
    } cfg_t;

    // Work handed from geometry front to shading back.
    typedef struct packed {
        logic signed [33:0] dot;   // dot(outgoing, normal), Q.28
        logic [16:0]        base;  // |dot(incoming, reflected)|, Q1.16, clipped
    } work_t;

    // log2(1 + k/2^tb) in Q0.16, by repeated squaring.
    function automatic logic [15:0] log_entry(input int unsigned k, input int unsigned tb);
        logic [63:0] x;
        logic [31:0] bits;
        logic [31:0] r;
        x    = (64'd1 << 30) + (64'(k) << (30 - tb));
        bits = '0;
        for (int i = 0; i < 20; i++) begin
            x    = (x * x) >> 30;
            bits = bits << 1;
            if (x >= (64'd1 << 31)) begin
                bits = bits | 32'd1;
                x    = x >> 1;
            end
        end
        r = (bits + 32'd8) >> 4;
        return r[15:0];
    endfunction

    // 2^(-k/2^tb) in Q1.16, by series for e^-y.
    function automatic logic [16:0] exp_entry(input int unsigned k, input int unsigned tb);
        logic [63:0]        y;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        r;
        y    = ((64'(k) << (30 - tb)) * LN2_Q30) >> 30;
        term = 64'd1 << 32;
        sum  = $signed(term);
        for (int n = 1; n <= 20; n++) begin
            term = ((term * y) >> 30) / 64'(n);
            if (n % 2 == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        r = ($unsigned(sum) + 64'd32768) >> 16;
        return r[16:0];
    endfunction

endpackage

@@ rtl/core/pbe_front.sv @@
// Geometry front: dot(out, n), reflection of out about n, specular base.
// Depends on pbe_pkg.
module pbe_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [143:0]  in_data,
    output logic          push_valid,
    input  logic          push_ready,
    output pbe_pkg::work_t push_item
);
    import pbe_pkg::*;

    logic [4:0] valid_reg;
    logic       adv;

    logic signed [15:0] vi1_reg [NUM_CH];
    logic signed [15:0] vo1_reg [NUM_CH];
    logic signed [15:0] vn1_reg [NUM_CH];
    logic signed [15:0] vi2_reg [NUM_CH];
    logic signed [15:0] vo2_reg [NUM_CH];
    logic signed [15:0] vn2_reg [NUM_CH];
    logic signed [15:0] vi3_reg [NUM_CH];
    logic signed [23:0] r3_reg  [NUM_CH];
    logic signed [23:0] r3_next [NUM_CH];
    logic signed [33:0] d2_reg, d3_reg, d4_reg, d5_reg;
    logic signed [33:0] d2_next;
    logic signed [41:0] t4_reg, t4_next;
    logic [16:0]        b5_reg, b5_next;
    logic [41:0]        t_abs;
    logic [29:0]        t_rnd;

    assign adv      = !valid_reg[4] || push_ready;
    assign in_ready = adv;

    // stage 2: dot(out, n)
    assign d2_next = 34'(vo1_reg[0] * vn1_reg[0]) + 34'(vo1_reg[1] * vn1_reg[1])
                   + 34'(vo1_reg[2] * vn1_reg[2]);

    // stage 3: r = out - rnd(2 d n / 2^28)
    always_comb begin
        logic signed [50:0] prod;
        for (int c = 0; c < NUM_CH; c++) begin
            prod = ((51'(d2_reg) * 51'(vn2_reg[c])) <<< 1) + (51'sd1 <<< 27);
            prod = prod >>> 28;
            r3_next[c] = 24'(vo2_reg[c]) - prod[23:0];
        end
    end

    // stage 4: dot(in, r)
    assign t4_next = (42'(vi3_reg[0]) * 42'(r3_reg[0]))
                   + (42'(vi3_reg[1]) * 42'(r3_reg[1]))
                   + (42'(vi3_reg[2]) * 42'(r3_reg[2]));

    // stage 5: magnitude, round to Q1.16, clip at one
    assign t_abs   = (t4_reg < 0) ? $unsigned(-t4_reg) : $unsigned(t4_reg);
    assign t_rnd   = 30'((t_abs + 42'd2048) >> 12);
    assign b5_next = (t_rnd > 30'(ONE_Q16)) ? ONE_Q16 : t_rnd[16:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int c = 0; c < NUM_CH; c++) begin
                vi1_reg[c] <= in_data[16*c +: 16];
                vo1_reg[c] <= in_data[48 + 16*c +: 16];
                vn1_reg[c] <= in_data[96 + 16*c +: 16];
                vi2_reg[c] <= vi1_reg[c];
                vo2_reg[c] <= vo1_reg[c];
                vn2_reg[c] <= vn1_reg[c];
                vi3_reg[c] <= vi2_reg[c];
                r3_reg[c]  <= r3_next[c];
            end
            d2_reg <= d2_next;
            d3_reg <= d2_reg;
            d4_reg <= d3_reg;
            d5_reg <= d4_reg;
            t4_reg <= t4_next;
            b5_reg <= b5_next;
        end
    end

    assign push_valid     = valid_reg[4];
    assign push_item.dot  = d5_reg;
    assign push_item.base = b5_reg;

endmodule

@@ rtl/core/pbe_queue.sv @@
// Short FIFO between the geometry front and the shading back.
// Depends on pbe_pkg and the assertion macro header.
module pbe_queue #(
    parameter int unsigned DEPTH = pbe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  pbe_pkg::work_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output pbe_pkg::work_t pop_item
);
    import pbe_pkg::*;
    `include "phong_brdf_evaluation_assert.svh"

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    work_t          entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           push_fire, pop_fire;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    assign count_next  = count_reg + CW'(push_fire) - CW'(pop_fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_fire) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop_fire) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_fire) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    `PBE_ASSERT_NEXT(a_count_tracks, 1'b1, count_reg == $past(count_reg) + CW'($past(push_fire)) - CW'($past(pop_fire)))
    `PBE_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CW'(DEPTH))
    `PBE_ASSERT_NEXT(a_head_holds, pop_valid && !pop_ready, pop_item == $past(pop_item))

endmodule

@@ rtl/core/pbe_back.sv @@
// Shading back: power by log2/exp2 tables, color terms, round and saturate.
// Depends on pbe_pkg.
module pbe_back #(
    parameter int unsigned LOG_TABLE_BITS = pbe_pkg::LOG_TABLE_BITS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  pbe_pkg::cfg_t  cfg,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  pbe_pkg::work_t pop_item,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [63:0]    out_data
);
    import pbe_pkg::*;

    localparam int unsigned TB   = LOG_TABLE_BITS;
    localparam int unsigned TSZ  = 1 << TB;

    logic [15:0] log_rom [TSZ];
    logic [16:0] exp_rom [TSZ];

    for (genvar g = 0; g < TSZ; g++) begin : g_rom
        assign log_rom[g] = log_entry(g, TB);
        assign exp_rom[g] = exp_entry(g, TB);
    end

    logic [6:0] valid_reg;
    logic       adv;

    // S1
    work_t              it1_reg;
    // S2
    logic signed [33:0] d2_reg, d3_reg, d4_reg, d5_reg;
    logic               one2_reg, one3_reg, one4_reg;
    logic               zero2_reg, zero3_reg, zero4_reg;
    logic [4:0]         sh2_reg, sh2_next;
    logic [15:0]        lg2_reg;
    logic [TB-1:0]      k2;
    // S3
    logic [36:0]        q3_reg, q3_next;
    // S4
    logic [12:0]        n4_reg;
    logic [16:0]        e4_reg;
    // S5
    logic [16:0]        p5_reg, p5_next;
    // S6
    logic signed [50:0] pd6_reg [NUM_CH];
    logic [32:0]        ps6_reg [NUM_CH];
    // S7
    logic [19:0]        sh7_next [NUM_CH];
    logic [19:0]        sh7_reg  [NUM_CH];

    assign adv       = !valid_reg[6] || out_ready;
    assign pop_ready = adv;

    // leading one and mantissa index
    always_comb begin
        logic [3:0]  p;
        logic [31:0] fr;
        p = '0;
        for (int i = 0; i < 16; i++) begin
            if (it1_reg.base[i]) begin
                p = 4'(i);
            end
        end
        sh2_next = 5'd16 - 5'(p);
        fr       = 32'(it1_reg.base[15:0]) << sh2_next;
        k2       = fr[15 -: TB];
    end

    // m = (16-p) - log2(mantissa), times shininess
    always_comb begin
        logic [20:0] m;
        m       = {sh2_reg, 16'd0} - 21'(lg2_reg);
        q3_next = 37'(m) * 37'(cfg.shininess);
    end

    // scale the exp2 entry by 2^-n with rounding, or force one or zero
    always_comb begin
        logic [17:0] rs;
        rs = (18'(e4_reg) + (18'd1 << (n4_reg[4:0] - 5'd1))) >> n4_reg[4:0];
        if (one4_reg) begin
            p5_next = ONE_Q16;
        end else if (zero4_reg || n4_reg > 13'd16) begin
            p5_next = '0;
        end else if (n4_reg == 13'd0) begin
            p5_next = e4_reg;
        end else begin
            p5_next = rs[16:0];
        end
    end

    // sum of terms, round to Q8.12, saturate
    always_comb begin
        logic signed [52:0] acc;
        logic signed [52:0] rd;
        for (int c = 0; c < NUM_CH; c++) begin
            acc = 53'(pd6_reg[c]) + $signed({8'd0, ps6_reg[c], 12'd0});
            rd  = (acc + (53'sd1 <<< 27)) >>> 28;
            if (rd > 53'(SAT_MAX)) begin
                sh7_next[c] = SAT_MAX[19:0];
            end else if (rd < 53'(SAT_MIN)) begin
                sh7_next[c] = SAT_MIN[19:0];
            end else begin
                sh7_next[c] = rd[19:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[5:0], pop_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            it1_reg   <= pop_item;
            d2_reg    <= it1_reg.dot;
            one2_reg  <= (cfg.shininess == '0) || (it1_reg.base >= ONE_Q16);
            zero2_reg <= (it1_reg.base == '0);
            sh2_reg   <= sh2_next;
            lg2_reg   <= log_rom[k2];
            d3_reg    <= d2_reg;
            one3_reg  <= one2_reg;
            zero3_reg <= zero2_reg;
            q3_reg    <= q3_next;
            d4_reg    <= d3_reg;
            one4_reg  <= one3_reg;
            zero4_reg <= zero3_reg;
            n4_reg    <= q3_reg[36:24];
            e4_reg    <= exp_rom[q3_reg[23 -: TB]];
            d5_reg    <= d4_reg;
            p5_reg    <= p5_next;
            for (int c = 0; c < NUM_CH; c++) begin
                pd6_reg[c] <= 51'($signed({1'b0, cfg.diffuse[c]})) * 51'(d5_reg);
                ps6_reg[c] <= 33'(cfg.specular[c]) * 33'(p5_reg);
                sh7_reg[c] <= sh7_next[c];
            end
        end
    end

    assign out_valid = valid_reg[6];
    assign out_data  = {4'd0, sh7_reg[2], sh7_reg[1], sh7_reg[0]};

endmodule

@@ rtl/core/phong_brdf_evaluation.sv @@
// Top level of the Phong shading core: config registers, front, queue, back.
// Depends on pbe_pkg, pbe_front, pbe_queue, pbe_back.
//
// Usage:
//   s_axis: one transaction per shading sample: incoming, outgoing and normal
//     vectors, signed Q1.14. m_axis: one transaction per sample, the red,
//     green and blue shade values, signed Q8.12, saturated, in input order.
//   cfg: register writes (diffuse RGB, specular RGB, shininess). cfg_ready is
//     always high; index 7 is ignored. Write only while the core is drained.
//   Throughput: one sample per cycle when m_axis is not stalled.
//   Path: from s_axis transaction to m_axis valid, 5 geometry
//     stages (input register, dot, reflection, dot, abs/round), the queue
//     entry register, 7 shading stages (input register, log2 table,
//     multiply by shininess, exp2 table, scale, color multiplies, sum and
//     saturate).
//   Stall: front and back each hold when their downstream is full; the queue
//     between them absorbs the skew. s_axis_tready drops only once the
//     queue is full and the last front stage holds a transaction.
//   Reset: aresetn low (synchronous) empties all stages and the queue and
//     loads diffuse and specular 1.0, shininess 1.0.
module phong_brdf_evaluation #(
    parameter int unsigned LOG_TABLE_BITS = pbe_pkg::LOG_TABLE_BITS_DEF,
    parameter int unsigned QUEUE_DEPTH    = pbe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // incoming_x, _y, _z, outgoing_x, _y, _z, normal_x, _y, _z (16 bits each)
    input  logic [143:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // shade_red, shade_green, shade_blue (20 bits each), 4 zero bits
    output logic [63:0]   m_axis_tdata,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [pbe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]   cfg_data
);
    import pbe_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  push_valid, push_ready;
    logic  pop_valid, pop_ready;
    work_t push_item, pop_item;

    assign cfg_ready = 1'b1;

    // register file write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_DIFFUSE_RED:    cfg_next.diffuse[0]  = cfg_data;
                CFG_DIFFUSE_GREEN:  cfg_next.diffuse[1]  = cfg_data;
                CFG_DIFFUSE_BLUE:   cfg_next.diffuse[2]  = cfg_data;
                CFG_SPECULAR_RED:   cfg_next.specular[0] = cfg_data;
                CFG_SPECULAR_GREEN: cfg_next.specular[1] = cfg_data;
                CFG_SPECULAR_BLUE:  cfg_next.specular[2] = cfg_data;
                CFG_SHININESS:      cfg_next.shininess   = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.diffuse   <= {NUM_CH{COLOR_RESET}};
            cfg_reg.specular  <= {NUM_CH{COLOR_RESET}};
            cfg_reg.shininess <= SHINE_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    pbe_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    pbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    pbe_back #(
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for phong_brdf_evaluation: random and directed shading samples,
// checked against an in-bench fixed-point Phong predictor. Depends on pbe_pkg and the RTL.
module testbench;
    import pbe_pkg::*;

    localparam int TB      = 10;            // log table bits, matches the DUT default
    localparam int TSIZE   = 1 << TB;
    localparam int LATENCY = 13;

    typedef struct packed {
        logic signed [15:0] nz, ny, nx, oz, oy, ox, iz, iy, ix;
    } sample_t;

    typedef struct packed {
        logic [19:0] blue, green, red;
    } shade_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [143:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    phong_brdf_evaluation u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),   // incoming xyz, outgoing xyz, normal xyz
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),   // shade red, green, blue, 4 zero bits
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Predictor state: register shadow and the fixed log2/exp2 tables.
    logic [15:0] diff_col [3];
    logic [15:0] spec_col [3];
    logic [15:0] shine;
    longint log2_lut [TSIZE];
    longint exp2_lut [TSIZE];

    sample_t pending_samples [$];
    shade_t  expected_shades [$];
    int      errors = 0;
    int      sender_idle_pct = 0;
    int      receiver_stall_pct = 0;
    int      hold_off_cycles = 0;     // long receiver hold-off, counted down by the receiver

    // Build tables by the same arithmetic the hardware uses: repeated squaring for log2,
    // alternating series for e^-y.
    task automatic build_luts();
        longint unsigned x, bits, y, term;
        longint sum;
        for (int k = 0; k < TSIZE; k++) begin
            x = (64'd1 << 30) + (64'(k) << (30 - TB));
            bits = 0;
            for (int i = 0; i < 20; i++) begin
                x = (x * x) >> 30;
                bits = bits << 1;
                if (x >= (64'd1 << 31)) begin
                    bits = bits | 1;
                    x = x >> 1;
                end
            end
            log2_lut[k] = (bits + 8) >> 4;
        end
        for (int k = 0; k < TSIZE; k++) begin
            y = ((64'(k) << (30 - TB)) * LN2_Q30) >> 30;
            term = 64'd1 << 32;
            sum = longint'(term);
            for (int n = 1; n <= 20; n++) begin
                term = ((term * y) >> 30) / n;
                if (n % 2 == 1) sum = sum - longint'(term);
                else sum = sum + longint'(term);
            end
            exp2_lut[k] = (sum + 32768) >>> 16;
        end
    endtask

    // floor((v + 2^(k-1)) / 2^k); arithmetic shift is a floor in SV.
    function automatic longint round_shift(longint v, int k);
        return (v + (64'sd1 <<< (k - 1))) >>> k;
    endfunction

    function automatic longint specular_power(longint b, longint ex);
        int p;
        longint frac, m, q, n, j, e;
        if (ex == 0 || b >= 65536) return 65536;
        if (b == 0) return 0;
        p = 15;
        while (((b >> p) & 1) == 0) p--;
        frac = (b << (16 - p)) & 16'hFFFF;
        m = (16 - p) * 65536 - log2_lut[frac >> (16 - TB)];
        q = m * ex;
        n = q >> 24;
        if (n > 16) return 0;
        j = (q & 24'hFFFFFF) >> (24 - TB);
        e = exp2_lut[j];
        if (n == 0) return e;
        return (e + (64'sd1 << (n - 1))) >> n;
    endfunction

    function automatic shade_t shade_sample(sample_t s);
        longint vi [3], vo [3], vn [3], r [3];
        longint d, t, b, pw, acc, v;
        logic [19:0] ch [3];
        vi = '{s.ix, s.iy, s.iz};
        vo = '{s.ox, s.oy, s.oz};
        vn = '{s.nx, s.ny, s.nz};
        d = 0;
        t = 0;
        for (int c = 0; c < 3; c++) d += vo[c] * vn[c];
        for (int c = 0; c < 3; c++) begin
            r[c] = vo[c] - round_shift(2 * d * vn[c], 28);
            t += vi[c] * r[c];
        end
        if (t < 0) t = -t;
        b = round_shift(t, 12);
        if (b > 65536) b = 65536;
        pw = specular_power(b, longint'(shine));
        for (int c = 0; c < 3; c++) begin
            acc = longint'(diff_col[c]) * d + ((longint'(spec_col[c]) * pw) <<< 12);
            v = round_shift(acc, 28);
            if (v > 524287) v = 524287;
            if (v < -524288) v = -524288;
            ch[c] = v[19:0];
        end
        return '{blue: ch[2], green: ch[1], red: ch[0]};
    endfunction

    // Driver: feeds pending samples, computes expectations on the accepting edge.
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready)
            expected_shades.push_back(shade_sample(sample_t'(s_axis_tdata)));
    end

    always @(negedge aclk) begin
        if (aresetn && !(s_axis_tvalid && !s_axis_tready)) begin
            // Previous transaction done (or none offered): pick next one or idle.
            if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_samples.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compares each shade transaction with the oldest expectation.
    always @(posedge aclk) begin
        shade_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[59:0];
            if (expected_shades.size() == 0) begin
                $error("unexpected shade transaction %h", got);
                errors++;
            end else begin
                want = expected_shades.pop_front();
                if (got.red !== want.red) begin
                    $error("shade_red expected %h got %h", want.red, got.red);
                    errors++;
                end
                if (got.green !== want.green) begin
                    $error("shade_green expected %h got %h", want.green, got.green);
                    errors++;
                end
                if (got.blue !== want.blue) begin
                    $error("shade_blue expected %h got %h", want.blue, got.blue);
                    errors++;
                end
            end
        end
    end

    // Receiver backpressure, with an optional long hold-off to fill the pipeline.
    always @(negedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx <= CFG_SPECULAR_BLUE) begin
            if (idx <= CFG_DIFFUSE_BLUE) diff_col[idx] = val;
            else spec_col[idx - CFG_SPECULAR_RED] = val;
        end else begin
            shine = val;
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(logic [15:0] d [3], logic [15:0] s [3], logic [15:0] sh);
        for (int c = 0; c < 3; c++) write_reg(cfg_idx_t'(CFG_DIFFUSE_RED + c), d[c]);
        for (int c = 0; c < 3; c++) write_reg(cfg_idx_t'(CFG_SPECULAR_RED + c), s[c]);
        write_reg(CFG_SHININESS, sh);
    endtask

    task automatic drain();
        while (pending_samples.size() != 0 || s_axis_tvalid || expected_shades.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic logic signed [15:0] unit_comp();
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    // Random sample: mostly components within +-16384 (+-1.0), sometimes any 16-bit pattern.
    function automatic sample_t rand_sample();
        sample_t s;
        if ($urandom_range(9) < 2) begin
            s = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
        end else begin
            s = '{nz: unit_comp(), ny: unit_comp(), nx: unit_comp(), oz: unit_comp(),
                  oy: unit_comp(), ox: unit_comp(), iz: unit_comp(), iy: unit_comp(),
                  ix: unit_comp()};
            // Mirror setup: incoming set to outgoing with its x component negated.
            if ($urandom_range(3) == 0) begin
                s.ix = -s.ox; s.iy = s.oy; s.iz = s.oz;
            end
        end
        return s;
    endfunction

    function automatic sample_t make_sample(int i0, int i1, int i2, int o0, int o1, int o2,
                                            int n0, int n1, int n2);
        return '{ix: 16'(i0), iy: 16'(i1), iz: 16'(i2), ox: 16'(o0), oy: 16'(o1),
                 oz: 16'(o2), nx: 16'(n0), ny: 16'(n1), nz: 16'(n2)};
    endfunction

    task automatic run_phase(int count, int idle, int stall);
        sender_idle_pct = idle;
        receiver_stall_pct = stall;
        for (int i = 0; i < count; i++) pending_samples.push_back(rand_sample());
        drain();
    endtask

    initial begin
        logic [15:0] d [3], s [3];
        build_luts();
        diff_col = '{COLOR_RESET, COLOR_RESET, COLOR_RESET};
        spec_col = '{COLOR_RESET, COLOR_RESET, COLOR_RESET};
        shine = SHINE_RESET;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset registers, extremes, mirror, zero base, negative dot, -32768.
        pending_samples.push_back(make_sample(0, 0, 16384, 0, 0, 16384, 0, 0, 16384));
        pending_samples.push_back(make_sample(0, 0, -16384, 0, 0, 16384, 0, 0, 16384));
        pending_samples.push_back(make_sample(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
        pending_samples.push_back(make_sample(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_samples.push_back(make_sample(0, 0, 16384, 0, 0, -16384, 0, 0, 16384));
        pending_samples.push_back(make_sample(-32768, -32768, -32768, -32768, -32768, -32768,
                                              -32768, -32768, -32768));
        pending_samples.push_back(make_sample(32767, 32767, 32767, 32767, 32767, 32767,
                                              32767, 32767, 32767));
        pending_samples.push_back(make_sample(-11585, 0, 11585, 11585, 0, 11585, 0, 0, 16384));
        pending_samples.push_back(make_sample(8000, 0, 14000, 11585, 0, 11585, 0, 0, 16384));
        pending_samples.push_back(make_sample(100, 0, 50, 0, 0, 16384, 0, 0, 16384));
        drain();

        // Extremes of the registers: max colors with large shininess, then zero diffuse and shininess.
        d = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
        s = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
        write_all(d, s, 16'hFFFF);
        // Unknown index 7: ignored by the block, predictor untouched.
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= '1;
        cfg_data  <= 16'h1234;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        for (int i = 0; i < 8; i++) pending_samples.push_back(rand_sample());
        pending_samples.push_back(make_sample(0, 0, 16384, 0, 0, -16384, 0, 0, 16384));
        drain();
        d = '{16'h0000, 16'h0000, 16'h0000};
        write_all(d, s, 16'h0000);
        for (int i = 0; i < 6; i++) pending_samples.push_back(rand_sample());
        drain();

        // Random register settings, one per phase, across the backpressure mixes.
        for (int ph = 0; ph < 4; ph++) begin
            for (int c = 0; c < 3; c++) begin
                d[c] = $urandom;
                s[c] = $urandom_range(8192);
            end
            write_all(d, s, (ph == 0) ? 16'h0080 : 16'($urandom_range(4096)));
            case (ph)
                0: run_phase(280, 0, 0);
                1: run_phase(280, 53, 0);
                2: run_phase(280, 0, 53);
                default: run_phase(280, 20, 20);
            endcase
        end

        // Long receiver hold-off while the sender keeps offering: fills the core.
        sender_idle_pct = 0;
        receiver_stall_pct = 10;
        for (int i = 0; i < 40; i++) pending_samples.push_back(rand_sample());
        @(negedge aclk);
        hold_off_cycles <= 60;
        drain();

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/pbe_pkg.sv
rtl/core/pbe_front.sv
rtl/core/pbe_queue.sv
rtl/core/pbe_back.sv
rtl/core/phong_brdf_evaluation.sv
sim/testbench.sv
